@@ rtl/lfpd_pkg.sv @@
// lfpd_pkg: shared constants, types and codes of the line follower PD drive.
// No dependencies; every other file of the block depends on this package.
package lfpd_pkg;

  localparam int NUM_SENSORS      = 7;
  localparam int SAMPLE_BITS_DEF  = 12;
  localparam int SPEED_BITS       = 7;
  localparam int CFG_IDX_BITS     = 3;

  // Register map: indexes 0..6 are the per-sensor thresholds.
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_SPEED = 3'd7;

  localparam int GAIN_OFFSET      = 1000;
  localparam int KD_RATIO         = 50;
  localparam int GAIN_SCALE       = 100000;
  localparam int SPEED_MAX        = 100;
  localparam int PIVOT_SPEED      = 25;
  localparam int SEARCH_SPEED     = 40;
  localparam int BASE_SPEED_RESET = 20;

  // Holds base_speed * GAIN_SCALE and the unsaturated band below SPEED_MAX * GAIN_SCALE.
  localparam int SCALED_BITS      = 24;

  // floor(x / 100000) == (x * ceil(2^40 / 100000)) >> 40 for every x below 1e7.
  localparam int RECIP_SHIFT      = 40;
  localparam logic [SCALED_BITS-1:0] RECIP_MULT = 24'd10995117;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_PD,
    ST_MUL,
    ST_SUM,
    ST_DIVL,
    ST_DIVR,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_SEEK_POS,
    RULE_SEEK_NEG,
    RULE_PIVOT_LEFT,
    RULE_PIVOT_RIGHT,
    RULE_PD
  } rule_t;

  typedef struct packed {
    logic [NUM_SENSORS-1:0] above;
    logic [NUM_SENSORS-1:0] below;
  } cmp_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } err_sign_t;

endpackage

@@ rtl/lfpd_if.sv @@
// lfpd_frame_if / lfpd_drive_if: valid-ready channels of the drive block.
// Depends on lfpd_pkg for default sample width and speed width.
interface lfpd_frame_if #(parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_0;
  logic [SAMPLE_BITS-1:0] sample_1;
  logic [SAMPLE_BITS-1:0] sample_2;
  logic [SAMPLE_BITS-1:0] sample_3;
  logic [SAMPLE_BITS-1:0] sample_4;
  logic [SAMPLE_BITS-1:0] sample_5;
  logic [SAMPLE_BITS-1:0] sample_6;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                  sample_5, sample_6, input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                  sample_5, sample_6, output ready);
endinterface

interface lfpd_drive_if;
  logic                            valid;
  logic                            ready;
  logic [lfpd_pkg::SPEED_BITS-1:0] left_speed;
  logic [lfpd_pkg::SPEED_BITS-1:0] right_speed;
  logic                            left_reverse;
  logic                            right_reverse;

  modport source (output valid, left_speed, right_speed, left_reverse, right_reverse,
                  input ready);
  modport sink   (input valid, left_speed, right_speed, left_reverse, right_reverse,
                  output ready);
endinterface

@@ rtl/lfpd_lane.sv @@
// lfpd_lane: one sensor lane, strict compare of a sample against its threshold.
// Depends on lfpd_pkg for the default sample width.
module lfpd_lane #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] threshold,
  output logic                   above,
  output logic                   below
);

  // equal counts as neither
  assign above = sample > threshold;
  assign below = sample < threshold;

endmodule

@@ rtl/lfpd_merge.sv @@
// lfpd_merge: combines the seven lane flags and the stored error sign into a rule.
// Depends on lfpd_pkg (cmp_t, err_sign_t, rule_t).
module lfpd_merge (
  input  lfpd_pkg::cmp_t      cmp,
  input  lfpd_pkg::err_sign_t err,
  output lfpd_pkg::rule_t     rule
);
  import lfpd_pkg::*;

  logic lost;

  assign lost = (&cmp.above) || !(|cmp.above);

  always_comb begin
    rule = RULE_NONE;
    if (lost) begin
      if (err.pos) begin
        rule = RULE_SEEK_POS;
      end else if (err.neg) begin
        rule = RULE_SEEK_NEG;
      end
    end else if (cmp.above[0] && cmp.below[NUM_SENSORS-1]) begin
      rule = RULE_PIVOT_LEFT;
    end else if (cmp.below[0] && cmp.above[NUM_SENSORS-1]) begin
      rule = RULE_PIVOT_RIGHT;
    end else if (cmp.above[NUM_SENSORS/2]) begin
      rule = RULE_PD;
    end
  end

endmodule

@@ rtl/line_follow_pid_drive.sv @@
// line_follow_pid_drive: top level, seven compare lanes, rule merge and PD sequencer.
// Depends on lfpd_pkg, lfpd_frame_if / lfpd_drive_if, lfpd_lane and lfpd_merge.
//
//   channel  dir  handshake     word
//   frame    in   valid/ready   sample_0..sample_6, SAMPLE_BITS each
//   drive    out  valid/ready   left_speed, right_speed, left_reverse, right_reverse
//   cfg      in   cfg_we        cfg_index (0..6 thresholds, 7 base_speed), cfg_data
//
// One frame at a time. The sequencer steps a PD frame through compare, PD sum, gain
// multiply, speed sum, then two reciprocal multiplies through one shared multiplier,
// then output load. Lost-line and pivot frames go from compare to output load; frames
// with no result return to idle after compare.
// rst (sync, active high) clears thresholds, base_speed (to 20), last_error and
// the output valid flag. A waiting drive word does not block the next frame; only a new
// word bound for the drive register waits for it to empty.
module line_follow_pid_drive #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lfpd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]            cfg_data,
  lfpd_frame_if.sink                        frame,
  lfpd_drive_if.source                      drive
);
  import lfpd_pkg::*;

  // Arithmetic widths, all signed but QW (the unsigned reciprocal product).
  localparam int EW = SAMPLE_BITS + 1;                          // error s1 - s5
  localparam int GOFF_BITS = $clog2(GAIN_OFFSET + 1) + 1;
  localparam int GW = (SAMPLE_BITS + 1 > GOFF_BITS) ? SAMPLE_BITS + 1 : GOFF_BITS;
  localparam int PW = SAMPLE_BITS + 8;                          // 51*e - 50*last
  localparam int NW = GW + PW;                                  // gain * pd
  localparam int XW = NW + 1;                                   // base*scale +/- n
  localparam int QW = 2 * SCALED_BITS;

  localparam logic signed [GW-1:0] G_OFF = GW'(GAIN_OFFSET);
  localparam logic signed [PW-1:0] K_E   = PW'(KD_RATIO + 1);
  localparam logic signed [PW-1:0] K_L   = PW'(KD_RATIO);
  localparam logic signed [XW-1:0] X_LO  = XW'(GAIN_SCALE);
  localparam logic signed [XW-1:0] X_HI  = XW'(GAIN_SCALE * SPEED_MAX);

  // Configuration
  logic [SAMPLE_BITS-1:0] thr [NUM_SENSORS];
  logic [SPEED_BITS-1:0]  base_speed;

  // Frame capture and sequencer
  logic [SAMPLE_BITS-1:0] smp [NUM_SENSORS];
  state_t                 state, state_next;
  logic                   frame_ready;
  logic                   accept;
  logic                   load_out;

  // Lane results and rule
  wire  [NUM_SENSORS-1:0] above_w;
  wire  [NUM_SENSORS-1:0] below_w;
  cmp_t                   cmp;
  err_sign_t              err_sign;
  rule_t                  rule_w;
  rule_t                  rule_r;

  // PD datapath
  logic signed [EW-1:0]   last_error;
  logic signed [EW-1:0]   err_w, err_r;
  logic signed [GW-1:0]   gain_w, gain_r;
  logic signed [PW-1:0]   e_x, l_x, pd_w, pd_r;
  logic signed [NW-1:0]   prod_w, n_r;
  logic [SCALED_BITS-1:0] base_scaled;
  logic signed [XW-1:0]   base_x, n_x, xl, xr;
  logic [SCALED_BITS-1:0] frac_l, frac_r, div_in;
  logic                   lo_l, hi_l, lo_r, hi_r;
  logic [QW-1:0]          qprod;
  logic [SPEED_BITS-1:0]  quot;
  logic [SPEED_BITS-1:0]  spd_l, spd_r;
  logic                   rev_l, rev_r;

  // Drive word register
  logic                   out_valid;
  logic [SPEED_BITS-1:0]  out_l, out_r;
  logic                   out_lrev, out_rrev;

  function automatic logic [SPEED_BITS-1:0] sat_speed(input logic lo, input logic hi,
                                                      input logic [SPEED_BITS-1:0] q);
    logic [SPEED_BITS-1:0] res;
    if (lo) begin
      res = '0;
    end else if (hi) begin
      res = SPEED_BITS'(SPEED_MAX);
    end else begin
      res = q;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        thr[i] <= '0;
      end
      base_speed <= SPEED_BITS'(BASE_SPEED_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_SPEED: base_speed     <= cfg_data[SPEED_BITS-1:0];
        default:        thr[cfg_index] <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------------- capture
  assign accept      = frame.valid && frame_ready;
  assign frame.ready = frame_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      smp[0] <= frame.sample_0;
      smp[1] <= frame.sample_1;
      smp[2] <= frame.sample_2;
      smp[3] <= frame.sample_3;
      smp[4] <= frame.sample_4;
      smp[5] <= frame.sample_5;
      smp[6] <= frame.sample_6;
    end
  end

  // ---------------------------------------------------------------- lanes
  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    lfpd_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .sample   (smp[g]),
      .threshold(thr[g]),
      .above    (above_w[g]),
      .below    (below_w[g])
    );
  end

  assign cmp.above    = above_w;
  assign cmp.below    = below_w;
  assign err_sign.neg = last_error[EW-1];
  assign err_sign.pos = !last_error[EW-1] && (last_error != '0);

  lfpd_merge u_merge (
    .cmp (cmp),
    .err (err_sign),
    .rule(rule_w)
  );

  // ---------------------------------------------------------------- datapath
  // error and gain come straight off the captured frame
  assign err_w  = $signed({1'b0, smp[1]}) - $signed({1'b0, smp[5]});
  assign gain_w = G_OFF - $signed({{(GW - SAMPLE_BITS){1'b0}}, smp[NUM_SENSORS/2]});

  // Kp*e + Kd*(e - last) scaled by 1e5 -> gain * (51*e - 50*last)
  assign e_x  = {{(PW - EW){err_r[EW-1]}}, err_r};
  assign l_x  = {{(PW - EW){last_error[EW-1]}}, last_error};
  assign pd_w = e_x * K_E - l_x * K_L;

  // GW x PW signed product; the operands carry only sign extension above that
  assign prod_w = {{(NW - GW){gain_r[GW-1]}}, gain_r} * {{(NW - PW){pd_r[PW-1]}}, pd_r};

  assign base_scaled = SCALED_BITS'(base_speed) * SCALED_BITS'(GAIN_SCALE);
  assign base_x      = $signed({{(XW - SCALED_BITS){1'b0}}, base_scaled});
  assign n_x         = {n_r[NW-1], n_r};
  assign xl          = base_x - n_x;
  assign xr          = base_x + n_x;

  // Shared divide-by-1e5; only reached inside the unsaturated band, where it is exact.
  assign div_in = (state == ST_DIVL) ? frac_l : frac_r;
  assign qprod  = QW'(div_in) * QW'(RECIP_MULT);
  assign quot   = qprod[RECIP_SHIFT +: SPEED_BITS];

  always_ff @(posedge clk) begin
    case (state)
      ST_CMP: begin
        err_r  <= err_w;
        gain_r <= gain_w;
        rule_r <= rule_w;
        rev_l  <= (rule_w == RULE_PIVOT_LEFT);
        rev_r  <= (rule_w == RULE_PIVOT_RIGHT);
        case (rule_w)
          RULE_SEEK_POS: begin
            spd_l <= '0;
            spd_r <= SPEED_BITS'(SEARCH_SPEED);
          end
          RULE_SEEK_NEG: begin
            spd_l <= SPEED_BITS'(SEARCH_SPEED);
            spd_r <= '0;
          end
          RULE_PIVOT_LEFT, RULE_PIVOT_RIGHT: begin
            spd_l <= SPEED_BITS'(PIVOT_SPEED);
            spd_r <= SPEED_BITS'(PIVOT_SPEED);
          end
          default: begin
            spd_l <= '0;
            spd_r <= '0;
          end
        endcase
      end
      ST_PD:  pd_r <= pd_w;
      ST_MUL: n_r  <= prod_w;
      ST_SUM: begin
        // truncation toward zero: anything below one scale step is speed 0
        lo_l   <= xl < X_LO;
        hi_l   <= xl >= X_HI;
        frac_l <= xl[SCALED_BITS-1:0];
        lo_r   <= xr < X_LO;
        hi_r   <= xr >= X_HI;
        frac_r <= xr[SCALED_BITS-1:0];
      end
      ST_DIVL: spd_l <= sat_speed(lo_l, hi_l, quot);
      ST_DIVR: spd_r <= sat_speed(lo_r, hi_r, quot);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    frame_ready = 1'b0;
    load_out    = 1'b0;
    case (state)
      ST_IDLE: begin
        frame_ready = 1'b1;
        if (frame.valid) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rule_w == RULE_NONE) begin
          state_next = ST_IDLE;
        end else if (rule_w == RULE_PD) begin
          state_next = ST_PD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_PD:   state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIVL;
      ST_DIVL: state_next = ST_DIVR;
      ST_DIVR: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || drive.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // last_error moves only when a PD word is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
    end else if (load_out && (rule_r == RULE_PD)) begin
      last_error <= err_r;
    end
  end

  // ---------------------------------------------------------------- drive word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (drive.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_l    <= spd_l;
      out_r    <= spd_r;
      out_lrev <= rev_l;
      out_rrev <= rev_r;
    end
  end

  assign drive.valid         = out_valid;
  assign drive.left_speed    = out_l;
  assign drive.right_speed   = out_r;
  assign drive.left_reverse  = out_lrev;
  assign drive.right_reverse = out_rrev;

  // ---------------------------------------------------------------- checks
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_l <= SPEED_BITS'(SPEED_MAX)) && (out_r <= SPEED_BITS'(SPEED_MAX)))
    else $error("drive speed above limit");

  a_pivot_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_lrev || out_rrev) |->
      !(out_lrev && out_rrev) && (out_l == SPEED_BITS'(PIVOT_SPEED)) &&
      (out_r == SPEED_BITS'(PIVOT_SPEED)))
    else $error("reverse set outside a pivot word");

  a_err_update: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(last_error) |-> $past(load_out && (rule_r == RULE_PD)))
    else $error("last_error changed without a PD word");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) && out_valid && !drive.ready |=> (state == ST_OUT))
    else $error("new word left while drive register full");

  a_accept_cmp: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CMP))
    else $error("accepted frame not compared next cycle");

endmodule
